// File: rtl/core/prtl_pkg.sv
// Shared types, codes and sizes for the prefix route table lookup block.
package prtl_pkg;

  localparam int MAX_ROUTES = 32;
  localparam int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W      = $clog2(MAX_ROUTES + 1);

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_APPEND  = 2'd1;
  localparam logic [1:0] MODE_IFACE   = 2'd2;
  localparam logic [1:0] MODE_GATEWAY = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NO_ROUTE = 3'd2;
  localparam logic [2:0] ST_IFACE    = 3'd3;
  localparam logic [2:0] ST_VIA      = 3'd4;
  localparam logic [2:0] ST_DEST     = 3'd5;

  localparam logic [7:0] V4_PLEN_MAX = 8'd32;
  localparam logic [7:0] V6_PLEN_MAX = 8'd128;
  localparam logic [63:0] V4_HI_MASK = {32'hFFFF_FFFF, 32'h0};

  typedef struct packed {
    logic [1:0]  mode;
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;
    logic [15:0] metric;
    logic [63:0] net_id;
    logic [3:0]  iface;
    logic [63:0] via_hi;
    logic [63:0] via_lo;
    logic [31:0] local_addr;
    logic [31:0] local_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  out_iface;
    logic [63:0] gw_hi;
    logic [63:0] gw_lo;
  } out_item_t;

  // One stored route, as held in a single memory word.
  typedef struct packed {
    logic [3:0]  iface;
    logic [15:0] metric;
    logic [7:0]  plen;
    logic        v6;
    logic [63:0] target_hi;
    logic [63:0] target_lo;
    logic [63:0] via_hi;
    logic [63:0] via_lo;
    logic [63:0] net_id;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

  typedef struct packed {
    logic        start;
    logic        v6;
    logic [63:0] dhi;
    logic [63:0] dlo;
    logic        any_iface;
    logic [3:0]  want;
  } scan_req_t;

  typedef struct packed {
    logic        done;
    logic        found;
    logic [3:0]  iface;
    logic [63:0] via_hi;
    logic [63:0] via_lo;
  } scan_res_t;

endpackage

// File: rtl/core/prtl_if.sv
// Valid/ready channel interfaces for input items and result items.
interface prtl_in_if import prtl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface prtl_out_if import prtl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: rtl/core/prtl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module prtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/prtl_scan.sv
// Route scan engine: reads stored routes one per cycle and keeps the best match.
module prtl_scan import prtl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  scan_req_t        req_in,
  input  logic [CNT_W-1:0] count,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  route_t           rd_data,
  output scan_res_t        res
);

  logic             busy;
  logic [CNT_W-1:0] ptr;
  logic             rvalid;
  scan_req_t        req;

  logic        best_found;
  logic [7:0]  best_plen;
  logic [15:0] best_metric;
  logic [63:0] best_net_id;
  logic [3:0]  best_iface;
  logic [63:0] best_via_hi;
  logic [63:0] best_via_lo;

  logic [7:0]  plen_cap;
  logic [63:0] mask_hi;
  logic [63:0] mask_lo;
  logic        pfx_hit;
  logic        fam_ok;
  logic        iface_ok;
  logic        better;
  logic        take;

  assign rd_en   = busy && (ptr != count);
  assign rd_addr = ptr[IDX_W-1:0];

  // Match and ranking of the entry that the memory returned this cycle.
  always_comb begin
    plen_cap = rd_data.plen;
    if (!rd_data.v6 && (rd_data.plen > V4_PLEN_MAX)) begin
      plen_cap = V4_PLEN_MAX;
    end else if (rd_data.v6 && (rd_data.plen > V6_PLEN_MAX)) begin
      plen_cap = V6_PLEN_MAX;
    end
    for (int b = 0; b < 64; b++) begin
      mask_hi[b] = (63 - b) < int'(plen_cap);
      mask_lo[b] = (127 - b) < int'(plen_cap);
    end
    pfx_hit  = (((req.dhi ^ rd_data.target_hi) & mask_hi) == 64'd0) &&
               (((req.dlo ^ rd_data.target_lo) & mask_lo) == 64'd0);
    fam_ok   = (rd_data.v6 == req.v6);
    iface_ok = req.any_iface ? (rd_data.iface != 4'd0) : (rd_data.iface == req.want);
    // Strict ordering, so an equal route keeps the earlier one.
    better   = !best_found ||
               (rd_data.plen > best_plen) ||
               ((rd_data.plen == best_plen) && (rd_data.metric < best_metric)) ||
               ((rd_data.plen == best_plen) && (rd_data.metric == best_metric) &&
                (rd_data.net_id < best_net_id));
    take     = rvalid && fam_ok && iface_ok && pfx_hit && better;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      ptr        <= '0;
      rvalid     <= 1'b0;
      best_found <= 1'b0;
    end else begin
      rvalid <= rd_en;
      if (req_in.start) begin
        busy       <= 1'b1;
        ptr        <= '0;
        best_found <= 1'b0;
      end else if (busy) begin
        if (rd_en) begin
          ptr <= ptr + CNT_W'(1);
        end
        if (take) begin
          best_found <= 1'b1;
        end
        if (!rd_en && !rvalid) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_in.start) begin
      req <= req_in;
    end
    if (take) begin
      best_plen   <= rd_data.plen;
      best_metric <= rd_data.metric;
      best_net_id <= rd_data.net_id;
      best_iface  <= rd_data.iface;
      best_via_hi <= rd_data.via_hi;
      best_via_lo <= rd_data.via_lo;
    end
  end

  always_comb begin
    res.done   = busy && !rd_en && !rvalid;
    res.found  = best_found;
    res.iface  = best_iface;
    res.via_hi = best_via_hi;
    res.via_lo = best_via_lo;
  end

endmodule

// File: rtl/core/prefix_route_table_lookup.sv
// Top level of the longest-prefix-match route table with its control sequencer.
//
// Items arrive on in_ch and one result per item leaves on out_ch; both are
// valid/ready channels and a transfer happens when valid and ready are high
// at a rising edge of clk. A clear or append item passes through S_EMIT into
// the output register, as does a gateway query that is answered without a
// search (no interface, or an IPv4 on-link destination). An interface or
// gateway lookup first reads the stored routes one per cycle from the route
// memory in S_SCAN, then passes through S_EMIT. The block works on one item
// at a time and takes the next item once the previous result sits in the
// output register. A stalled receiver holds the result in the output
// register; a following result waits in the sequencer until the held one
// has been transferred. Synchronous reset empties the table and drops any
// pending result; route memory contents are not cleared, as entries at or
// above the route count are never read.
module prefix_route_table_lookup import prtl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  prtl_in_if.sink      in_ch,
  prtl_out_if.source   out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] route_count;
  logic             out_valid;
  out_item_t        out_item;
  out_item_t        res;

  logic [1:0]  q_mode;
  logic        q_v6;
  logic [63:0] q_addr_hi;
  logic [63:0] q_addr_lo;
  logic [3:0]  q_iface;

  logic       accept;
  logic       emit;
  logic [2:0] acc_status;
  logic       table_full;
  logic       off_link;
  logic       gw_search;
  logic       wr_en;
  route_t     wr_route;
  scan_req_t  sreq;
  scan_res_t  sres;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ROUTE_W-1:0] rd_word;
  logic [63:0] v_hi;
  logic [63:0] v_lo;
  out_item_t   lookup_res;

  assign in_ch.ready  = (state == S_IDLE) && !rst;
  assign accept       = in_ch.valid && in_ch.ready;
  assign emit         = (state == S_EMIT) && (!out_valid || out_ch.ready);
  assign out_ch.valid = out_valid;
  assign out_ch.item  = out_item;

  assign table_full = (route_count == CNT_W'(MAX_ROUTES));
  assign off_link   = (in_ch.item.addr_hi[63:32] & in_ch.item.local_mask) !=
                      (in_ch.item.local_addr & in_ch.item.local_mask);
  assign gw_search  = (in_ch.item.iface != 4'd0) && (in_ch.item.is_v6 || off_link);
  assign wr_en      = accept && (in_ch.item.mode == MODE_APPEND) && !table_full;

  always_comb begin
    wr_route.iface     = in_ch.item.iface;
    wr_route.metric    = in_ch.item.metric;
    wr_route.plen      = in_ch.item.prefix_len;
    wr_route.v6        = in_ch.item.is_v6;
    wr_route.target_hi = in_ch.item.addr_hi;
    wr_route.target_lo = in_ch.item.addr_lo;
    wr_route.via_hi    = in_ch.item.via_hi;
    wr_route.via_lo    = in_ch.item.via_lo;
    wr_route.net_id    = in_ch.item.net_id;

    sreq.start     = accept && ((in_ch.item.mode == MODE_IFACE) ||
                                ((in_ch.item.mode == MODE_GATEWAY) && gw_search));
    sreq.v6        = in_ch.item.is_v6;
    sreq.dhi       = in_ch.item.addr_hi;
    sreq.dlo       = in_ch.item.addr_lo;
    sreq.any_iface = (in_ch.item.mode == MODE_IFACE);
    sreq.want      = in_ch.item.iface;

    if (in_ch.item.mode == MODE_APPEND) begin
      acc_status = table_full ? ST_FULL : ST_DONE;
    end else if (in_ch.item.mode == MODE_GATEWAY) begin
      acc_status = ST_NO_ROUTE;
    end else begin
      acc_status = ST_DONE;
    end
  end

  prtl_ram #(
    .WIDTH (ROUTE_W),
    .DEPTH (MAX_ROUTES)
  ) u_route_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (route_count[IDX_W-1:0]),
    .wr_data (wr_route),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  prtl_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .req_in  (sreq),
    .count   (route_count),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (route_t'(rd_word)),
    .res     (sres)
  );

  // Result of a finished search; IPv4 keeps only bits 63:32 of the upper half of an address.
  always_comb begin
    v_hi = q_v6 ? sres.via_hi : (sres.via_hi & V4_HI_MASK);
    v_lo = q_v6 ? sres.via_lo : 64'd0;
    lookup_res = '0;
    if (!sres.found) begin
      lookup_res.status = ST_NO_ROUTE;
    end else if (q_mode == MODE_IFACE) begin
      lookup_res.status    = ST_IFACE;
      lookup_res.out_iface = sres.iface;
    end else if ((v_hi != 64'd0) || (v_lo != 64'd0)) begin
      lookup_res.status    = ST_VIA;
      lookup_res.out_iface = q_iface;
      lookup_res.gw_hi     = v_hi;
      lookup_res.gw_lo     = v_lo;
    end else begin
      lookup_res.status    = ST_DEST;
      lookup_res.out_iface = q_iface;
      lookup_res.gw_hi     = q_v6 ? q_addr_hi : (q_addr_hi & V4_HI_MASK);
      lookup_res.gw_lo     = q_v6 ? q_addr_lo : 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      route_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_ch.item.mode)
              MODE_CLEAR: begin
                route_count <= '0;
                state       <= S_EMIT;
              end
              MODE_APPEND: begin
                if (!table_full) begin
                  route_count <= route_count + CNT_W'(1);
                end
                state <= S_EMIT;
              end
              MODE_IFACE: begin
                state <= S_SCAN;
              end
              MODE_GATEWAY: begin
                state <= gw_search ? S_SCAN : S_EMIT;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (sres.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mode    <= in_ch.item.mode;
      q_v6      <= in_ch.item.is_v6;
      q_addr_hi <= in_ch.item.addr_hi;
      q_addr_lo <= in_ch.item.addr_lo;
      q_iface   <= in_ch.item.iface;
      res       <= '{status: acc_status, out_iface: 4'd0, gw_hi: 64'd0, gw_lo: 64'd0};
    end else if ((state == S_SCAN) && sres.done) begin
      res <= lookup_res;
    end
    if (emit) begin
      out_item <= res;
    end
  end

endmodule

// File: tb/prtl_tb_pkg.sv
// Shadow copy of the route table that predicts and checks every result of the block.
package prtl_tb_pkg;
  import prtl_pkg::*;

  // Leading-bit mask of a stored prefix, with the length capped to the family width.
  function automatic logic [127:0] lead_mask(logic [7:0] plen, logic v6);
    int p;
    p = int'(plen);
    if (!v6 && p > int'(V4_PLEN_MAX)) p = int'(V4_PLEN_MAX);
    if (p > int'(V6_PLEN_MAX)) p = int'(V6_PLEN_MAX);
    return (p == 0) ? '0 : (~128'h0 << (128 - p));
  endfunction

  class route_table_shadow;
    route_t      routes[MAX_ROUTES];
    int unsigned count;
    out_item_t   expected_results[$];
    int unsigned mismatches;
    int unsigned orphan_results;
    int unsigned checked;
    int unsigned status_seen[8];

    function new();
      count = 0;
      mismatches = 0;
      orphan_results = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function int unsigned failures();
      return mismatches + orphan_results;
    endfunction

    function bit covers(int unsigned i, logic [127:0] dest);
      logic [127:0] tgt;
      tgt = {routes[i].target_hi, routes[i].target_lo};
      return ((dest ^ tgt) & lead_mask(routes[i].plen, routes[i].v6)) == '0;
    endfunction

    // Ordering uses the stored length, not the capped one.
    function bit outranks(int unsigned i, int unsigned j);
      if (routes[i].plen != routes[j].plen) return routes[i].plen > routes[j].plen;
      if (routes[i].metric != routes[j].metric) return routes[i].metric < routes[j].metric;
      return routes[i].net_id < routes[j].net_id;
    endfunction

    // Earlier entries win full ties because only a strictly better route replaces them.
    function int best_route(logic v6, logic [127:0] dest, bit any_iface, logic [3:0] want);
      int best;
      best = -1;
      for (int i = 0; i < int'(count); i++) begin
        if (routes[i].v6 != v6) continue;
        if (any_iface ? (routes[i].iface == 4'd0) : (routes[i].iface != want)) continue;
        if (!covers(i, dest)) continue;
        if (best < 0 || outranks(i, best)) best = i;
      end
      return best;
    endfunction

    function void note_item(in_item_t it);
      out_item_t   res;
      route_t      rt;
      int          r;
      logic [63:0] vh;
      logic [63:0] vl;
      res = '0;
      case (it.mode)
        MODE_CLEAR: begin
          count = 0;
          res.status = ST_DONE;
        end
        MODE_APPEND: begin
          if (count >= MAX_ROUTES) begin
            res.status = ST_FULL;
          end else begin
            rt.iface = it.iface;
            rt.metric = it.metric;
            rt.plen = it.prefix_len;
            rt.v6 = it.is_v6;
            rt.target_hi = it.addr_hi;
            rt.target_lo = it.addr_lo;
            rt.via_hi = it.via_hi;
            rt.via_lo = it.via_lo;
            rt.net_id = it.net_id;
            routes[count] = rt;
            count++;
            res.status = ST_DONE;
          end
        end
        MODE_IFACE: begin
          r = best_route(it.is_v6, {it.addr_hi, it.addr_lo}, 1'b1, 4'd0);
          if (r < 0) begin
            res.status = ST_NO_ROUTE;
          end else begin
            res.status = ST_IFACE;
            res.out_iface = routes[r].iface;
          end
        end
        default: begin
          res.status = ST_NO_ROUTE;
          if (it.iface != 4'd0 && (it.is_v6 ||
              ((it.addr_hi[63:32] & it.local_mask) != (it.local_addr & it.local_mask)))) begin
            r = best_route(it.is_v6, {it.addr_hi, it.addr_lo}, 1'b0, it.iface);
            if (r >= 0) begin
              vh = routes[r].via_hi;
              vl = routes[r].via_lo;
              if (!it.is_v6) begin
                vh = vh & V4_HI_MASK;
                vl = '0;
              end
              res.out_iface = it.iface;
              if (vh != '0 || vl != '0) begin
                res.status = ST_VIA;
                res.gw_hi = vh;
                res.gw_lo = vl;
              end else begin
                res.status = ST_DEST;
                res.gw_hi = it.is_v6 ? it.addr_hi : (it.addr_hi & V4_HI_MASK);
                res.gw_lo = it.is_v6 ? it.addr_lo : '0;
              end
            end
          end
        end
      endcase
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (failures() <= 200)
          $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        orphan_results++;
        if (failures() <= 200)
          $display("%0t: unexpected result: expected none, got status %0d iface %0d gw 0x%0h_%0h",
                   $time, got.status, got.out_iface, got.gw_hi, got.gw_lo);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      status_seen[got.status]++;
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("out_iface", 64'(want.out_iface), 64'(got.out_iface));
      compare_field("gw_hi", want.gw_hi, got.gw_hi);
      compare_field("gw_lo", want.gw_lo, got.gw_lo);
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// Top-level testbench: drives route items into the block and checks every result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prtl_pkg::*;
  import prtl_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  prtl_in_if  in_ch();
  prtl_out_if out_ch();

  prefix_route_table_lookup uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  route_table_shadow table_shadow = new();

  int unsigned   items_sent = 0;
  int unsigned   burst_left = 0;
  bit            held_off = 1'b0;
  logic [127:0]  base_v4[4];
  logic [127:0]  base_v6[4];

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [127:0] v4(logic [31:0] a);
    return {a, 96'h0};
  endfunction

  function automatic in_item_t mk(logic [1:0] mode, logic v6, logic [127:0] addr,
                                  logic [7:0] plen, logic [15:0] metric, logic [63:0] nid,
                                  logic [3:0] ifc, logic [127:0] via,
                                  logic [31:0] laddr, logic [31:0] lmask);
    in_item_t it;
    it.mode = mode;
    it.is_v6 = v6;
    {it.addr_hi, it.addr_lo} = addr;
    it.prefix_len = plen;
    it.metric = metric;
    it.net_id = nid;
    it.iface = ifc;
    {it.via_hi, it.via_lo} = via;
    it.local_addr = laddr;
    it.local_mask = lmask;
    return it;
  endfunction

  // Every field random; the shaped generators overwrite what matters.
  function automatic in_item_t noise_item(logic [1:0] mode);
    return mk(mode, 1'($urandom), {rand64(), rand64()}, 8'($urandom), 16'($urandom),
              rand64(), 4'($urandom), {rand64(), rand64()}, $urandom, $urandom);
  endfunction

  function automatic in_item_t route_item();
    in_item_t     it;
    logic [127:0] tgt;
    it = noise_item(MODE_APPEND);
    if ($urandom_range(0, 1) == 0)
      tgt = it.is_v6 ? base_v6[$urandom_range(0, 3)] : base_v4[$urandom_range(0, 3)];
    else
      tgt = {rand64(), rand64()};
    it.addr_hi = tgt[127:64];
    if (it.is_v6) it.addr_lo = tgt[63:0];
    if (!it.is_v6)
      it.prefix_len = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(33, 255)
                                                      : $urandom_range(0, 32));
    else
      it.prefix_len = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(129, 255)
                                                      : $urandom_range(0, 128));
    case ($urandom_range(0, 3))
      0: it.metric = 16'($urandom_range(0, 2));
      1: it.metric = 16'hFFFF;
      default: ;
    endcase
    if ($urandom_range(0, 1) == 0) it.net_id = 64'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 7) it.iface = 4'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0, 1: {it.via_hi, it.via_lo} = '0;
      2: it.via_hi[63:32] = '0;
      default: ;
    endcase
    return it;
  endfunction

  // Destinations mostly fall inside a stored prefix so that the search has work to do.
  function automatic in_item_t query_item(logic [1:0] mode);
    in_item_t     it;
    route_t       rt;
    logic [127:0] dest;
    int unsigned  m;
    it = noise_item(mode);
    if (table_shadow.count != 0 && $urandom_range(0, 9) < 7) begin
      rt = table_shadow.routes[$urandom_range(0, table_shadow.count - 1)];
      it.is_v6 = ($urandom_range(0, 9) == 0) ? ~rt.v6 : rt.v6;
      dest = {rt.target_hi, rt.target_lo};
      if ($urandom_range(0, 3) != 0)
        dest = dest ^ ({rand64(), rand64()} & ~lead_mask(rt.plen, rt.v6));
      {it.addr_hi, it.addr_lo} = dest;
      if ($urandom_range(0, 3) != 0) it.iface = rt.iface;
    end else begin
      if ($urandom_range(0, 1) == 0) begin
        dest = it.is_v6 ? base_v6[$urandom_range(0, 3)] : base_v4[$urandom_range(0, 3)];
        {it.addr_hi, it.addr_lo} = dest ^ {16'h0, rand64(), 48'($urandom)};
      end
      if ($urandom_range(0, 9) < 7) it.iface = 4'($urandom_range(0, 3));
    end
    m = $urandom_range(8, 30);
    case ($urandom_range(0, 9))
      0: it.local_mask = '0;
      1, 2: begin
        it.local_mask = ~(32'hFFFF_FFFF >> m);
        it.local_addr = (it.addr_hi[63:32] & it.local_mask) | ($urandom & ~it.local_mask);
      end
      3, 4, 5, 6: it.local_mask = ~(32'hFFFF_FFFF >> m);
      default: ;
    endcase
    return it;
  endfunction

  // The sender works in bursts; the gap before a burst is a run of idle cycles.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.item <= it;
    do @(posedge clk); while (!in_ch.ready);
    table_shadow.note_item(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (table_shadow.pending() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    send_item(mk(MODE_CLEAR, 1'b0, '0, 8'd0, 16'd0, 64'd0, 4'd0, '0, 32'd0, 32'd0));
    send_item(mk(MODE_IFACE, 1'b0, v4(32'h0A01_0909), 8'd0, 16'd0, 64'd0, 4'd0, '0, 32'd0, 32'd0));
    send_item(mk(MODE_APPEND, 1'b0, v4(32'h0A00_0000), 8'd8, 16'd10, 64'd5, 4'd1, '0,
                 32'd0, 32'd0));
    send_item(mk(MODE_APPEND, 1'b0, v4(32'h0A01_0000), 8'd16, 16'hFFFF, '1, 4'd2,
                 v4(32'h0A00_0001), 32'd0, 32'd0));
    send_item(mk(MODE_APPEND, 1'b0, v4(32'h0A01_0000), 8'd16, 16'd0, 64'd7, 4'd3,
                 v4(32'h0A00_0003), 32'd0, 32'd0));
    send_item(mk(MODE_APPEND, 1'b0, v4(32'h0A01_0000), 8'd16, 16'd0, 64'd3, 4'd4,
                 v4(32'h0A00_0004), 32'd0, 32'd0));
    send_item(mk(MODE_APPEND, 1'b0, v4(32'h0A01_0000), 8'd16, 16'd0, 64'd3, 4'd5,
                 v4(32'h0A00_0005), 32'd0, 32'd0));
    send_item(mk(MODE_APPEND, 1'b0, '0, 8'd0, 16'd0, 64'd0, 4'd0, '1, 32'd0, 32'd0));
    send_item(mk(MODE_APPEND, 1'b0, v4(32'h0A01_0203), 8'd200, 16'd0, 64'd0, 4'd6,
                 v4(32'hC0A8_0001), 32'd0, 32'd0));
    send_item(mk(MODE_APPEND, 1'b1, {64'h2001_0DB8_0000_0000, 64'h0}, 8'd32, 16'd1, 64'd0,
                 4'd7, '0, 32'd0, 32'd0));
    send_item(mk(MODE_APPEND, 1'b1, {64'h2001_0DB8_0001_0000, 64'h0}, 8'd255, 16'd1, 64'd0,
                 4'd7, '1, 32'd0, 32'd0));
    // Only bits 63:32 of an IPv4 via count, so this gateway reads as zero.
    send_item(mk(MODE_APPEND, 1'b0, '0, 8'd0, 16'd0, 64'd0, 4'd9,
                 {64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 32'd0, 32'd0));
    send_item(mk(MODE_IFACE, 1'b0, v4(32'h0A01_0909), 8'd0, 16'd0, 64'd0, 4'd0, '0, 32'd0, 32'd0));
    send_item(mk(MODE_IFACE, 1'b0, {32'h0A01_0203, 32'hFFFF_FFFF, 64'h55}, 8'd0, 16'd0, 64'd0,
                 4'd0, '0, 32'd0, 32'd0));
    send_item(mk(MODE_IFACE, 1'b0, v4(32'hC0A8_0001), 8'd0, 16'd0, 64'd0, 4'd0, '0, 32'd0, 32'd0));
    send_item(mk(MODE_IFACE, 1'b1, {64'h2001_0DB8_0001_0000, 64'h0}, 8'd0, 16'd0, 64'd0, 4'd0,
                 '0, 32'd0, 32'd0));
    send_item(mk(MODE_IFACE, 1'b1, 128'h1, 8'd0, 16'd0, 64'd0, 4'd0, '0, 32'd0, 32'd0));
    send_item(mk(MODE_GATEWAY, 1'b0, v4(32'h0A01_0909), 8'd0, 16'd0, 64'd0, 4'd0, '0,
                 32'h0B00_0001, 32'hFF00_0000));
    send_item(mk(MODE_GATEWAY, 1'b0, v4(32'h0A01_0909), 8'd0, 16'd0, 64'd0, 4'd2, '0,
                 32'h0A01_0001, 32'hFFFF_0000));
    send_item(mk(MODE_GATEWAY, 1'b0, v4(32'h0A01_0909), 8'd0, 16'd0, 64'd0, 4'd2, '0,
                 32'h0B00_0001, 32'hFF00_0000));
    send_item(mk(MODE_GATEWAY, 1'b0, {32'h0A02_0304, 32'hDEAD_BEEF, 64'h1234}, 8'd0, 16'd0,
                 64'd0, 4'd1, '0, 32'h0B00_0001, 32'hFF00_0000));
    send_item(mk(MODE_GATEWAY, 1'b0, v4(32'hC0A8_0909), 8'd0, 16'd0, 64'd0, 4'd9, '0,
                 32'h0B00_0001, 32'hFF00_0000));
    send_item(mk(MODE_GATEWAY, 1'b1, {64'h2001_0DB8_0001_0000, 64'h5}, 8'd0, 16'd0, 64'd0, 4'd7,
                 '0, 32'd0, 32'd0));
    send_item(mk(MODE_GATEWAY, 1'b1, {64'h2001_0DB8_0001_0000, 64'h0}, 8'd0, 16'd0, 64'd0, 4'd7,
                 '0, 32'd0, 32'd0));
    send_item(mk(MODE_GATEWAY, 1'b0, v4(32'h0A01_0909), 8'd0, 16'd0, 64'd0, 4'd15, '0,
                 32'h0B00_0001, 32'hFFFF_FFFF));
  endtask

  // Each phase clears the table, loads fresh routes, then queries them amid appends and noise.
  task automatic run_random();
    int unsigned n;
    int unsigned choice;
    while (items_sent < 1750) begin
      if ($urandom_range(0, 3) == 0) wait_drained();
      send_item(noise_item(MODE_CLEAR));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
      repeat (n) send_item(route_item());
      n = $urandom_range(5, 40);
      repeat (n) begin
        choice = $urandom_range(0, 19);
        if (choice < 8) send_item(query_item(MODE_IFACE));
        else if (choice < 16) send_item(query_item(MODE_GATEWAY));
        else if (choice < 18) send_item(route_item());
        else send_item(noise_item(2'($urandom)));
      end
    end
  endtask

  // The receiver switches between steady, patchy and sparse acceptance, with one long hold-off.
  initial begin
    int unsigned pattern;
    int unsigned span;
    out_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      pattern = $urandom_range(0, 2);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        if (!held_off && table_shadow.checked >= 300) begin
          out_ch.ready <= 1'b0;
          repeat (500) @(negedge clk);
          held_off = 1'b1;
        end
        case (pattern)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) table_shadow.check_result(out_ch.item);
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.item = '0;
    foreach (base_v4[i]) base_v4[i] = v4($urandom);
    foreach (base_v6[i]) base_v6[i] = {rand64(), rand64()};
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    wait_drained();
    run_random();
    wait_drained();
    repeat (60) @(negedge clk);
    $display("Sent %0d items; checked %0d results: %0d table-full drops, %0d no-route,",
             items_sent, table_shadow.checked, table_shadow.status_seen[ST_FULL],
             table_shadow.status_seen[ST_NO_ROUTE]);
    $display("%0d interface hits, %0d via-gateway and %0d destination-gateway answers.",
             table_shadow.status_seen[ST_IFACE], table_shadow.status_seen[ST_VIA],
             table_shadow.status_seen[ST_DEST]);
    if (table_shadow.failures() == 0 && table_shadow.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, table_shadow.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
